FILE: sv/vmalu_pkg.sv
// Shared constants, opcode and status codes, and types for the VM register ALU.
// No dependencies. Imported by the divider, the register RAM user and the top level.
`default_nettype none

package vmalu_pkg;

  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W    = $clog2(DATA_W);

  localparam logic [3:0] REG_A = 4'd0;

  localparam logic [4:0] MODE_LOAD  = 5'd0;
  localparam logic [4:0] MODE_MOVR  = 5'd1;
  localparam logic [4:0] MODE_ADD   = 5'd2;
  localparam logic [4:0] MODE_SUB   = 5'd3;
  localparam logic [4:0] MODE_MUL   = 5'd4;
  localparam logic [4:0] MODE_MOD   = 5'd5;
  localparam logic [4:0] MODE_DIV   = 5'd6;
  localparam logic [4:0] MODE_INCR  = 5'd7;
  localparam logic [4:0] MODE_DECR  = 5'd8;
  localparam logic [4:0] MODE_EQ    = 5'd9;
  localparam logic [4:0] MODE_GE    = 5'd10;
  localparam logic [4:0] MODE_LE    = 5'd11;
  localparam logic [4:0] MODE_GOTO  = 5'd12;
  localparam logic [4:0] MODE_JMPZ  = 5'd13;
  localparam logic [4:0] MODE_JPNZ  = 5'd14;
  localparam logic [4:0] MODE_SHIFT = 5'd15;
  localparam logic [4:0] MODE_NOP   = 5'd16;
  localparam logic [4:0] MODE_END   = 5'd17;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_END = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? ('0 - v) : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/vmalu_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies; used for the register file.
`default_nettype none

module vmalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: sv/vmalu_div.sv
// Iterative signed divider: restoring division on magnitudes, one quotient bit per cycle.
// Depends on vmalu_pkg (widths, request/response structs, mag()).
`default_nettype none

module vmalu_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vmalu_pkg::div_req_t req,
  output vmalu_pkg::div_rsp_t      rsp
);

  import vmalu_pkg::*;

  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dmag_r, dmag_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;

  assign sh   = {rem_r, quo_r[DATA_W-1]};
  assign diff = sh - {1'b0, dmag_r};

  always_comb begin
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dmag_nxt  = dmag_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      quo_nxt   = mag(req.dividend);
      rem_nxt   = '0;
      dmag_nxt  = mag(req.divisor);
      neg_q_nxt = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
      neg_r_nxt = req.dividend[DATA_W-1];
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      // keep the shifted remainder when the trial subtract goes negative
      rem_nxt = diff[DATA_W] ? sh[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dmag_r  <= dmag_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = neg_q_r ? ('0 - quo_r) : quo_r;
  assign rsp.remainder = neg_r_r ? ('0 - rem_r) : rem_r;

endmodule

`default_nettype wire

FILE: sv/vm_register_alu_execute.sv
// Each accepted instruction passes through S_EXEC and then S_OUT; div and mod
// pass through S_DIV between them (one quotient bit per cycle in the shared divider).
// No new transaction is accepted while one is in flight;
// in_stall stays high from accept until the result transaction completes.
// Reset (synchronous, active low) clears code_base and reads all registers as zero.
// Depends on vmalu_pkg, vmalu_ram and vmalu_div.
`default_nettype none

module vm_register_alu_execute (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_mode,
  input  wire logic [3:0]  in_first_reg,
  input  wire logic [3:0]  in_second_reg,
  input  wire logic signed [31:0] in_immediate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_jump_taken,
  output logic [31:0]      out_jump_target,
  output logic             out_dest_written,
  output logic [3:0]       out_dest_index,
  output logic signed [31:0] out_dest_value
);

  import vmalu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              jt;
    logic [DATA_W-1:0] target;
    logic              wr;
    logic [3:0]        didx;
    logic [DATA_W-1:0] dval;
  } res_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] code_base_r;
  logic [4:0]        mode_r;
  logic [3:0]        rf_r;
  logic [3:0]        rs_r;
  logic [DATA_W-1:0] imm_r;
  logic              a_vld_r;
  logic              b_vld_r;
  logic [NUM_REGS-1:0] reg_valid_r;
  res_t              res_r;

  logic              accept;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic              rf_bad;
  logic              rs_bad;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] shl_cnt;
  logic [DATA_W-1:0] shift_val;
  logic              div_go;
  logic              finish;
  res_t              res;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // jmpz/jpnz test register A through port a
  assign raddr_a = (in_mode == MODE_JMPZ || in_mode == MODE_JPNZ) ? IDX_W'(REG_A)
                                                                  : in_first_reg[IDX_W-1:0];
  assign raddr_b = in_second_reg[IDX_W-1:0];

  vmalu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk     (clk),
    .we      (finish && res.wr),
    .waddr   (res.didx[IDX_W-1:0]),
    .wdata   (res.dval),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign a      = a_vld_r ? rdata_a : '0;
  assign b      = b_vld_r ? rdata_b : '0;
  assign rf_bad = ({1'b0, rf_r} >= 5'(NUM_REGS));
  assign rs_bad = ({1'b0, rs_r} >= 5'(NUM_REGS));
  assign prod   = a * b;

  // positive count: arithmetic right; negative count: left by its magnitude
  assign shl_cnt = '0 - imm_r;
  always_comb begin
    if (imm_r[DATA_W-1]) begin
      shift_val = (shl_cnt >= 32'd32) ? '0 : (a << shl_cnt[CNT_W-1:0]);
    end else if (imm_r >= 32'd32) begin
      shift_val = {DATA_W{a[DATA_W-1]}};
    end else begin
      shift_val = DATA_W'($signed(a) >>> imm_r[CNT_W-1:0]);
    end
  end

  always_comb begin
    res    = '0;
    div_go = 1'b0;
    if (state_r == S_DIV) begin
      res.wr   = 1'b1;
      res.didx = REG_A;
      res.dval = (mode_r == MODE_MOD) ? div_rsp.remainder : div_rsp.quotient;
    end else begin
      case (mode_r)
        MODE_LOAD: begin
          if (rf_bad) begin
            res.status = ST_ERR;
          end else begin
            res.wr   = 1'b1;
            res.didx = rf_r;
            res.dval = imm_r;
          end
        end
        MODE_MOVR: begin
          if (rf_bad || rs_bad) begin
            res.status = ST_ERR;
          end else begin
            res.wr   = 1'b1;
            res.didx = rf_r;
            res.dval = b;
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_EQ, MODE_GE, MODE_LE: begin
          if (rf_bad || rs_bad) begin
            res.status = ST_ERR;
          end else begin
            res.wr   = 1'b1;
            res.didx = REG_A;
            case (mode_r)
              MODE_ADD: res.dval = a + b;
              MODE_SUB: res.dval = a - b;
              MODE_MUL: res.dval = prod;
              MODE_EQ:  res.dval = DATA_W'(a == b);
              MODE_GE:  res.dval = DATA_W'($signed(a) >= $signed(b));
              default:  res.dval = DATA_W'($signed(a) <= $signed(b));
            endcase
          end
        end
        MODE_MOD, MODE_DIV: begin
          if (rf_bad || rs_bad || b == '0) begin
            res.status = ST_ERR;
          end else begin
            div_go = 1'b1;
          end
        end
        MODE_INCR, MODE_DECR: begin
          if (rf_bad) begin
            res.status = ST_ERR;
          end else begin
            res.wr   = 1'b1;
            res.didx = REG_A;
            res.dval = (mode_r == MODE_INCR) ? a + 1'b1 : a - 1'b1;
          end
        end
        MODE_GOTO: begin
          if (rf_bad) begin
            res.status = ST_ERR;
          end else begin
            res.jt     = 1'b1;
            res.target = code_base_r + a;
          end
        end
        MODE_JMPZ, MODE_JPNZ: begin
          if ((mode_r == MODE_JMPZ) == (a == '0)) begin
            res.jt     = 1'b1;
            res.target = code_base_r + imm_r;
          end
        end
        MODE_SHIFT: begin
          if (rf_bad) begin
            res.status = ST_ERR;
          end else begin
            res.wr   = 1'b1;
            res.didx = rf_r;
            res.dval = shift_val;
          end
        end
        MODE_NOP: begin
        end
        MODE_END: begin
          res.status = ST_END;
        end
        default: begin
          res.status = ST_ERR;
        end
      endcase
    end
  end

  assign div_req.start    = (state_r == S_EXEC) && div_go;
  assign div_req.dividend = a;
  assign div_req.divisor  = b;

  vmalu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign finish = ((state_r == S_EXEC) && !div_go) || ((state_r == S_DIV) && div_rsp.done);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = div_go ? S_DIV : S_OUT;
      S_DIV:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_base_r <= '0;
      reg_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        code_base_r <= cfg_wr_data;
      end
      if (finish && res.wr) begin
        reg_valid_r[res.didx[IDX_W-1:0]] <= 1'b1;
      end
    end
    if (accept) begin
      mode_r  <= in_mode;
      rf_r    <= in_first_reg;
      rs_r    <= in_second_reg;
      imm_r   <= in_immediate;
      a_vld_r <= reg_valid_r[raddr_a];
      b_vld_r <= reg_valid_r[raddr_b];
    end
    if (finish) begin
      res_r <= res;
    end
  end

  assign out_valid        = (state_r == S_OUT);
  assign out_status       = res_r.status;
  assign out_jump_taken   = res_r.jt;
  assign out_jump_target  = res_r.target;
  assign out_dest_written = res_r.wr;
  assign out_dest_index   = res_r.didx;
  assign out_dest_value   = res_r.dval;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_write_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && res.wr) |=> out_valid && out_dest_written)
    else $error("register write without matching result");

  a_err_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ERR) |-> (!out_dest_written && !out_jump_taken))
    else $error("error result carries a write or a jump");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

endmodule

`default_nettype wire
